// ===== rtl/dmx_pkg.sv =====
package dmx_pkg;

    // Frame store geometry: start code plus up to 512 slots.
    localparam int STORE_DEPTH = 513;
    localparam int LEN_W       = 10;

    // Field widths fixed by the interface.
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int ADDR_W      = 10;
    localparam int OUT_LATCHED = 6;
    localparam int CH_IDX_W    = 5;

    localparam logic [BYTE_W-1:0] DMX_START_CODE = 8'h00;
    localparam logic [BYTE_W-1:0] IDLE_SAT       = 8'd255;
    localparam logic [BYTE_W-1:0] STABLE_MAX     = 8'd255;
    localparam logic [BYTE_W-1:0] LATCH_THRESH   = 8'd2;
    localparam logic [LEN_W-1:0]  STORE_FULL     = 10'd513;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT    = 2'd1;

    localparam logic [ADDR_W-1:0] START_ADDRESS_RST = 10'd2;
    localparam logic [BYTE_W-1:0] IDLE_LIMIT_RST    = 8'd4;

    typedef enum logic [1:0] {
        MODE_BYTE     = 2'd0,
        MODE_BREAK    = 2'd1,
        MODE_TICK     = 2'd2,
        MODE_OVERFLOW = 2'd3
    } dmx_mode_t;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_APPLIED  = 2'd1,
        ST_DROPPED  = 2'd2,
        ST_OVF_CLR  = 2'd3
    } dmx_status_t;

    // One channel sample handed from the sequencer to the channel tracker.
    typedef struct packed {
        logic                valid;
        logic [CH_IDX_W-1:0] index;
        logic [BYTE_W-1:0]   value;
    } dmx_ch_upd_t;

endpackage

// ===== rtl/dmx_ram.sv =====
module dmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/dmx_chan.sv =====
module dmx_chan
    import dmx_pkg::*;
#(
    parameter int CHANNELS = 6
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dmx_ch_upd_t                      upd,
    output logic [CHANNELS-1:0][BYTE_W-1:0]  latched
);

    logic [CHANNELS-1:0][BYTE_W-1:0] prev_raw_reg, prev_raw_next;
    logic [CHANNELS-1:0][BYTE_W-1:0] stable_reg, stable_next;
    logic [CHANNELS-1:0][BYTE_W-1:0] latched_reg, latched_next;
    logic [BYTE_W-1:0]               prev_sel;
    logic [BYTE_W-1:0]               stable_sel;
    logic [BYTE_W-1:0]               stable_new;
    logic                            same;

    // Select the addressed channel for the shared compare.
    always_comb
    begin
        prev_sel   = '0;
        stable_sel = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (upd.index == CH_IDX_W'(i))
            begin
                prev_sel   = prev_raw_reg[i];
                stable_sel = stable_reg[i];
            end
        end
    end

    // Shared compare and saturating stability count.
    always_comb
    begin
        same = (upd.value == prev_sel);
        if (!same)
        begin
            stable_new = 8'd1;
        end
        else if (stable_sel < STABLE_MAX)
        begin
            stable_new = stable_sel + 8'd1;
        end
        else
        begin
            stable_new = stable_sel;
        end
    end

    // Write back into the addressed channel only.
    always_comb
    begin
        prev_raw_next = prev_raw_reg;
        stable_next   = stable_reg;
        latched_next  = latched_reg;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (upd.valid && upd.index == CH_IDX_W'(i))
            begin
                prev_raw_next[i] = upd.value;
                stable_next[i]   = stable_new;
                if (stable_new >= LATCH_THRESH)
                begin
                    latched_next[i] = upd.value;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg <= '0;
            stable_reg   <= '0;
            latched_reg  <= '0;
        end
        else
        begin
            prev_raw_reg <= prev_raw_next;
            stable_reg   <= stable_next;
            latched_reg  <= latched_next;
        end
    end

    assign latched = latched_reg;

endmodule

// ===== rtl/dmx_slot_capture_with_latch.sv =====
// A data byte, an overflow, or a break or tick that ends no frame gives its result in the
// cycle after the transfer. A frame runs S_SC_RD and S_SC_CHK; a dropped one then S_DONE, an
// applied one S_COPY over the copied slots (at most UNIVERSE_SLOTS; none skips S_COPY and
// S_DRAIN), S_DRAIN, S_SAMPLE over the channels, S_SWAIT and S_DONE. The copy runs through the
// single frame store read port. One item is in work at a time; the next transfer follows its
// result. Reset: state clears at once; the universe is then zeroed, no input.
module dmx_slot_capture_with_latch
    import dmx_pkg::*;
#(
    parameter int CHANNELS       = 6,
    parameter int UNIVERSE_SLOTS = 512
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Receive events
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            mode,
    input  logic [BYTE_W-1:0]     data_byte,
    // Results
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic [BYTE_W-1:0]     latched_ch0,
    output logic [BYTE_W-1:0]     latched_ch1,
    output logic [BYTE_W-1:0]     latched_ch2,
    output logic [BYTE_W-1:0]     latched_ch3,
    output logic [BYTE_W-1:0]     latched_ch4,
    output logic [BYTE_W-1:0]     latched_ch5,
    output logic [BYTE_W-1:0]     start_code_seen,
    output logic [CNT_W-1:0]      frames_applied,
    output logic [CNT_W-1:0]      breaks_seen,
    output logic [CNT_W-1:0]      overflows_seen,
    output logic [CNT_W-1:0]      bytes_seen,
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int UA_W  = $clog2(UNIVERSE_SLOTS);
    localparam int CH_CW = $clog2(CHANNELS + 1);
    localparam int SLOT_W = ADDR_W + 1;
    localparam logic [LEN_W-1:0]  SLOTS_L   = LEN_W'(UNIVERSE_SLOTS);
    localparam logic [LEN_W-1:0]  CLR_LAST  = LEN_W'(UNIVERSE_SLOTS - 1);
    localparam logic [SLOT_W-1:0] SLOTS_S   = SLOT_W'(UNIVERSE_SLOTS);
    localparam logic [CH_CW-1:0]  LAST_CH   = CH_CW'(CHANNELS - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SC_RD,
        S_SC_CHK,
        S_COPY,
        S_DRAIN,
        S_SAMPLE,
        S_SWAIT,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [BYTE_W-1:0]      idle_reg, idle_next;
    logic [BYTE_W-1:0]      sc_reg, sc_next;
    logic [ADDR_W-1:0]      start_addr_reg, start_addr_next;
    logic [BYTE_W-1:0]      idle_lim_reg, idle_lim_next;
    logic [CNT_W-1:0]       frames_reg, frames_next;
    logic [CNT_W-1:0]       breaks_reg, breaks_next;
    logic [CNT_W-1:0]       ovf_reg, ovf_next;
    logic [CNT_W-1:0]       bytes_reg, bytes_next;
    logic [LEN_W-1:0]       ptr_reg, ptr_next;
    logic [LEN_W-1:0]       last_reg, last_next;
    logic [CH_CW-1:0]       ch_reg, ch_next;
    logic                   cwr_v_reg, cwr_v_next;
    logic [UA_W-1:0]        cwr_addr_reg, cwr_addr_next;
    logic                   smp_v_reg, smp_v_next;
    logic                   smp_ok_reg, smp_ok_next;
    logic [CH_CW-1:0]       smp_ch_reg, smp_ch_next;
    dmx_status_t            fin_status_reg, fin_status_next;
    logic                   out_valid_reg, out_valid_next;
    dmx_status_t            out_status_reg, out_status_next;
    logic [OUT_LATCHED-1:0][BYTE_W-1:0] out_lat_reg, out_lat_next;
    logic [BYTE_W-1:0]      out_sc_reg, out_sc_next;
    logic [CNT_W-1:0]       out_frames_reg, out_frames_next;
    logic [CNT_W-1:0]       out_breaks_reg, out_breaks_next;
    logic [CNT_W-1:0]       out_ovf_reg, out_ovf_next;
    logic [CNT_W-1:0]       out_bytes_reg, out_bytes_next;

    logic                   accept;
    logic                   out_free;
    logic                   out_load;
    dmx_status_t            load_status;
    logic                   expired;
    logic [LEN_W-1:0]       len_m1;
    logic [SLOT_W-1:0]      slot;
    logic [SLOT_W-1:0]      slot_m1;

    logic                   fs_we;
    logic [LEN_W-1:0]       fs_raddr;
    logic [BYTE_W-1:0]      fs_rdata;
    logic                   u_we;
    logic [UA_W-1:0]        u_waddr;
    logic [BYTE_W-1:0]      u_wdata;
    logic [BYTE_W-1:0]      u_rdata;

    dmx_ch_upd_t                      ch_upd;
    logic [CHANNELS-1:0][BYTE_W-1:0]  latched;
    logic [OUT_LATCHED-1:0][BYTE_W-1:0] lat_ext;

    // Handshakes
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !(state_reg == S_IDLE && out_free);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Frame store: written by data bytes, read by the sequencer pointer.
    assign fs_we    = accept && (dmx_mode_t'(mode) == MODE_BYTE) && (len_reg < STORE_FULL);
    assign fs_raddr = ptr_reg;

    dmx_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (fs_we),
        .waddr (len_reg),
        .wdata (data_byte),
        .raddr (fs_raddr),
        .rdata (fs_rdata)
    );

    // Universe: zeroed by the clearing pass, filled by the copy, read by sampling.
    assign slot    = SLOT_W'(start_addr_reg) + SLOT_W'(ch_reg);
    assign slot_m1 = slot - SLOT_W'(1);
    assign u_we    = (state_reg == S_CLEAR) || cwr_v_reg;
    assign u_waddr = (state_reg == S_CLEAR) ? ptr_reg[UA_W-1:0] : cwr_addr_reg;
    assign u_wdata = (state_reg == S_CLEAR) ? '0 : fs_rdata;

    dmx_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (UNIVERSE_SLOTS)
    ) u_universe (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .raddr (slot_m1[UA_W-1:0]),
        .rdata (u_rdata)
    );

    // Channel tracker fed one sample per cycle.
    assign ch_upd.valid = smp_v_reg;
    assign ch_upd.index = CH_IDX_W'(smp_ch_reg);
    assign ch_upd.value = smp_ok_reg ? u_rdata : '0;

    dmx_chan #(
        .CHANNELS (CHANNELS)
    ) u_chan (
        .clk     (clk),
        .rst_n   (rst_n),
        .upd     (ch_upd),
        .latched (latched)
    );

    // Channels beyond CHANNELS read as zero.
    for (genvar j = 0; j < OUT_LATCHED; j++)
    begin : g_lat
        if (j < CHANNELS)
        begin : g_on
            assign lat_ext[j] = latched[j];
        end
        else
        begin : g_off
            assign lat_ext[j] = '0;
        end
    end

    assign expired = (idle_reg >= idle_lim_reg);
    assign len_m1  = len_reg - LEN_W'(1);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        idle_next       = idle_reg;
        sc_next         = sc_reg;
        start_addr_next = start_addr_reg;
        idle_lim_next   = idle_lim_reg;
        frames_next     = frames_reg;
        breaks_next     = breaks_reg;
        ovf_next        = ovf_reg;
        bytes_next      = bytes_reg;
        ptr_next        = ptr_reg;
        last_next       = last_reg;
        ch_next         = ch_reg;
        cwr_v_next      = 1'b0;
        cwr_addr_next   = cwr_addr_reg;
        smp_v_next      = 1'b0;
        smp_ok_next     = smp_ok_reg;
        smp_ch_next     = smp_ch_reg;
        fin_status_next = fin_status_reg;
        out_load        = 1'b0;
        load_status     = ST_NONE;

        // Configuration writes are taken in any state.
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_START_ADDRESS)
            begin
                start_addr_next = cfg_data[ADDR_W-1:0];
            end
            else if (cfg_index == REG_IDLE_LIMIT)
            begin
                idle_lim_next = cfg_data[BYTE_W-1:0];
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                ptr_next = ptr_reg + LEN_W'(1);
                if (ptr_reg == CLR_LAST)
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (dmx_mode_t'(mode))
                        MODE_BYTE:
                        begin
                            bytes_next = bytes_reg + CNT_W'(1);
                            idle_next  = '0;
                            if (len_reg < STORE_FULL)
                            begin
                                len_next = len_reg + LEN_W'(1);
                            end
                            out_load = 1'b1;
                        end
                        MODE_BREAK:
                        begin
                            breaks_next = breaks_reg + CNT_W'(1);
                            idle_next   = '0;
                            if (len_reg != '0)
                            begin
                                ptr_next   = '0;
                                state_next = S_SC_RD;
                            end
                            else
                            begin
                                out_load = 1'b1;
                            end
                        end
                        MODE_TICK:
                        begin
                            if (idle_reg < IDLE_SAT)
                            begin
                                idle_next = idle_reg + BYTE_W'(1);
                            end
                            if (len_reg != '0 && expired)
                            begin
                                ptr_next   = '0;
                                state_next = S_SC_RD;
                            end
                            else
                            begin
                                out_load = 1'b1;
                            end
                        end
                        default:
                        begin
                            ovf_next    = ovf_reg + CNT_W'(1);
                            len_next    = '0;
                            out_load    = 1'b1;
                            load_status = ST_OVF_CLR;
                        end
                    endcase
                end
            end
            S_SC_RD:
            begin
                state_next = S_SC_CHK;
            end
            S_SC_CHK:
            begin
                sc_next = fs_rdata;
                if (fs_rdata != DMX_START_CODE)
                begin
                    fin_status_next = ST_DROPPED;
                    len_next        = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    last_next = (len_m1 > SLOTS_L) ? SLOTS_L : len_m1;
                    ptr_next  = LEN_W'(1);
                    ch_next   = '0;
                    if (len_m1 == '0)
                    begin
                        state_next = S_SAMPLE;
                    end
                    else
                    begin
                        state_next = S_COPY;
                    end
                end
            end
            S_COPY:
            begin
                // Read slot k now, write universe entry k-1 next cycle.
                cwr_v_next    = 1'b1;
                cwr_addr_next = ptr_reg[UA_W-1:0] - UA_W'(1);
                ptr_next      = ptr_reg + LEN_W'(1);
                if (ptr_reg == last_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                ch_next    = '0;
                state_next = S_SAMPLE;
            end
            S_SAMPLE:
            begin
                smp_v_next  = 1'b1;
                smp_ch_next = ch_reg;
                smp_ok_next = (slot != '0) && (slot <= SLOTS_S);
                ch_next     = ch_reg + CH_CW'(1);
                if (ch_reg == LAST_CH)
                begin
                    state_next = S_SWAIT;
                end
            end
            S_SWAIT:
            begin
                frames_next     = frames_reg + CNT_W'(1);
                len_next        = '0;
                fin_status_next = ST_APPLIED;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    load_status = fin_status_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register: a snapshot of the state after the item.
    always_comb
    begin
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_lat_next    = out_lat_reg;
        out_sc_next     = out_sc_reg;
        out_frames_next = out_frames_reg;
        out_breaks_next = out_breaks_reg;
        out_ovf_next    = out_ovf_reg;
        out_bytes_next  = out_bytes_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = load_status;
            out_lat_next    = lat_ext;
            out_sc_next     = sc_next;
            out_frames_next = frames_next;
            out_breaks_next = breaks_next;
            out_ovf_next    = ovf_next;
            out_bytes_next  = bytes_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            len_reg        <= '0;
            idle_reg       <= '0;
            sc_reg         <= '0;
            start_addr_reg <= START_ADDRESS_RST;
            idle_lim_reg   <= IDLE_LIMIT_RST;
            frames_reg     <= '0;
            breaks_reg     <= '0;
            ovf_reg        <= '0;
            bytes_reg      <= '0;
            ptr_reg        <= '0;
            last_reg       <= '0;
            ch_reg         <= '0;
            cwr_v_reg      <= 1'b0;
            cwr_addr_reg   <= '0;
            smp_v_reg      <= 1'b0;
            smp_ok_reg     <= 1'b0;
            smp_ch_reg     <= '0;
            fin_status_reg <= ST_NONE;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_NONE;
            out_lat_reg    <= '0;
            out_sc_reg     <= '0;
            out_frames_reg <= '0;
            out_breaks_reg <= '0;
            out_ovf_reg    <= '0;
            out_bytes_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            idle_reg       <= idle_next;
            sc_reg         <= sc_next;
            start_addr_reg <= start_addr_next;
            idle_lim_reg   <= idle_lim_next;
            frames_reg     <= frames_next;
            breaks_reg     <= breaks_next;
            ovf_reg        <= ovf_next;
            bytes_reg      <= bytes_next;
            ptr_reg        <= ptr_next;
            last_reg       <= last_next;
            ch_reg         <= ch_next;
            cwr_v_reg      <= cwr_v_next;
            cwr_addr_reg   <= cwr_addr_next;
            smp_v_reg      <= smp_v_next;
            smp_ok_reg     <= smp_ok_next;
            smp_ch_reg     <= smp_ch_next;
            fin_status_reg <= fin_status_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_lat_reg    <= out_lat_next;
            out_sc_reg     <= out_sc_next;
            out_frames_reg <= out_frames_next;
            out_breaks_reg <= out_breaks_next;
            out_ovf_reg    <= out_ovf_next;
            out_bytes_reg  <= out_bytes_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign latched_ch0     = out_lat_reg[0];
    assign latched_ch1     = out_lat_reg[1];
    assign latched_ch2     = out_lat_reg[2];
    assign latched_ch3     = out_lat_reg[3];
    assign latched_ch4     = out_lat_reg[4];
    assign latched_ch5     = out_lat_reg[5];
    assign start_code_seen = out_sc_reg;
    assign frames_applied  = out_frames_reg;
    assign breaks_seen     = out_breaks_reg;
    assign overflows_seen  = out_ovf_reg;
    assign bytes_seen      = out_bytes_reg;

`ifndef SYNTHESIS
    // Items are only taken while the sequencer is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> (state_reg == S_IDLE))
        else $error("item transfer outside idle state");

    // The frame length never passes the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= STORE_FULL)
        else $error("frame length beyond store depth");

    // The universe is written only by the clearing pass or the copy.
    assert property (@(posedge clk) disable iff (!rst_n)
        u_we |-> (state_reg == S_CLEAR || state_reg == S_DRAIN || state_reg == S_COPY))
        else $error("universe written outside clear or copy");

    // A frame with a foreign start code is dropped right away.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SC_CHK && fs_rdata != DMX_START_CODE)
            |=> (state_reg == S_DONE && fin_status_reg == ST_DROPPED && len_reg == '0))
        else $error("foreign start code not dropped");

    // An applied frame bumps the frame counter by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWAIT) |=> (frames_reg == $past(frames_reg) + CNT_W'(1)))
        else $error("frame counter not advanced");
`endif

endmodule
